### design/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("escape decoder assertion failed");
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder assertion failed");
`define ESD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape decoder assertion failed");
`else
`define ESD_ASSERT(lbl, clk, rst_n, prop)
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ESD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/esd_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Escape decoder package
// Shared constants and the result list type passed from decoder to buffer.
// ------------------------------------------------------------------------
package esd_pkg;

    localparam int MaxResults = 5;
    localparam int ResCntW    = $clog2(MaxResults + 1);
    localparam int ResIdxW    = $clog2(MaxResults);

    // Configuration port
    localparam int  CfgAddrW  = 3;
    localparam logic RegPosix = 1'b0;   // register index as seen on paddr[2]

    // Characters
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChQuestion  = 8'h3F;
    localparam logic [7:0] ChLowerX    = 8'h78;
    localparam logic [7:0] ChLowerU    = 8'h75;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChNul       = 8'h00;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] data;
        logic [MaxResults-1:0]      err;
        logic [ResCntW-1:0]         cnt;
    } t_res;

endpackage

### design/escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Escape sequence decoder
// Decodes C-style backslash escapes in a byte stream, \u as UTF-8.
// ------------------------------------------------------------------------
// Usage:
//   Raw string bytes enter on the slave stream, one per request, with tlast
//   on the last byte of a string. Decoded bytes leave on the master stream;
//   tlast marks the last byte caused by one input byte and tuser flags a '?'
//   from a \u value that is out of range or a surrogate. A byte may cause no
//   output at all (it is held inside a pending escape) or up to five.
//   Flow: a byte is captured in the input register and decoded into the
//   result buffer once the buffer is free, so its first result is valid on
//   the master stream from the buffer register. Throughput is one input
//   byte per cycle while each byte gives at most one result and the
//   receiver is ready; a byte with more results holds the input until its
//   last result leaves the buffer.
//   When the receiver stalls the buffer keeps its results and the input
//   register fills, after which tready drops.
//   Reset (synchronous, active low) empties both registers, returns to plain
//   mode and clears posix_mode. posix_mode sits at APB byte address 0 and
//   the user must write it only while the stream is idle; the block does not enforce this.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_sequence_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Slave stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] in_byte
    input  logic                         i_s_tlast,   // end_of_string
    // Master stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [7:0]                   o_m_tdata,   // [7:0] out_byte
    output logic                         o_m_tlast,   // run_last
    output logic                         o_m_tuser,   // [0] conv_error
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esd_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import esd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       r_posix;
    logic       buf_free;
    logic       move;
    logic       in_take;
    t_res       dec_res;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == RegPosix) ? {31'd0, r_posix} : 32'd0;

    assign move       = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || move;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_posix    <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == RegPosix) begin
                r_posix <= pwdata[0];
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
            r_in_eos  <= i_s_tlast;
        end
    end

    esd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (move),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .i_posix (r_posix),
        .o_res   (dec_res)
    );

    esd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (move),
        .i_res   (dec_res),
        .i_ready (i_m_tready),
        .o_free  (buf_free),
        .o_valid (o_m_tvalid),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_err   (o_m_tuser)
    );

    // An accepted byte waits in the input register until it is decoded.
    `ESD_ASSERT_NXT(a_in_held, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_in_valid)
    // A stalled receiver never lets a new list overwrite pending results.
    `ESD_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !move)
    // A result that is not the last of its list is always followed by another.
    `ESD_ASSERT_NXT(a_run_cont, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tvalid)
    // A conversion error only ever carries the replacement character.
    `ESD_ASSERT_IMP(a_err_qmark, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
                    o_m_tdata == ChQuestion)

endmodule

### design/esd_decode.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Escape decoder step logic
// Holds the escape state and turns one registered byte into a result list.
// ------------------------------------------------------------------------
module esd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    input  logic          i_posix,
    output esd_pkg::t_res o_res
);
    import esd_pkg::*;

    localparam int OctDigits = 3;
    localparam int UniDigits = 8;

    typedef enum logic [2:0] {
        M_PLAIN, M_BSL, M_OCT, M_XSTART, M_XDIG, M_USTART, M_UDIG
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_val, n_val;
    logic [3:0]  r_cnt, n_cnt;
    t_res        res;
    logic        do_plain;
    logic        hex_ok;
    logic [3:0]  hex_v;
    logic        is_oct;
    logic [31:0] oct_acc;
    logic [31:0] uni_acc;
    logic [3:0]  cnt_inc;

    function automatic t_res push(t_res r, logic [7:0] b, logic e);
        t_res q;
        q = r;
        if (q.cnt < ResCntW'(MaxResults)) begin
            q.data[q.cnt[ResIdxW-1:0]] = b;
            q.err[q.cnt[ResIdxW-1:0]]  = e;
            q.cnt = q.cnt + 1'b1;
        end
        return q;
    endfunction

    function automatic t_res push_utf8(t_res r, logic [31:0] v);
        t_res q;
        q = r;
        if (v < 32'h80) begin
            q = push(q, v[7:0], 1'b0);
        end else if (v < 32'h800) begin
            q = push(q, {3'b110, v[10:6]}, 1'b0);
            q = push(q, {2'b10, v[5:0]}, 1'b0);
        end else if (v < 32'h10000) begin
            if (v >= 32'hD800 && v <= 32'hDFFF) begin
                q = push(q, ChQuestion, 1'b1);
            end else begin
                q = push(q, {4'b1110, v[15:12]}, 1'b0);
                q = push(q, {2'b10, v[11:6]}, 1'b0);
                q = push(q, {2'b10, v[5:0]}, 1'b0);
            end
        end else if (v <= 32'h10FFFF) begin
            q = push(q, {5'b11110, v[20:18]}, 1'b0);
            q = push(q, {2'b10, v[17:12]}, 1'b0);
            q = push(q, {2'b10, v[11:6]}, 1'b0);
            q = push(q, {2'b10, v[5:0]}, 1'b0);
        end else begin
            q = push(q, ChQuestion, 1'b1);
        end
        return q;
    endfunction

    function automatic logic [7:0] simple_escape(logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h61:   r = 8'h07;   // a
            8'h62:   r = 8'h08;   // b
            8'h66:   r = 8'h0C;   // f
            8'h6E:   r = 8'h0A;   // n
            8'h72:   r = 8'h0D;   // r
            8'h74:   r = 8'h09;   // t
            8'h76:   r = 8'h0B;   // v
            default: r = b;
        endcase
        return r;
    endfunction

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_v = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_v = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_oct  = (i_byte[7:3] == 5'b00110);
    assign oct_acc = {r_val[28:0], i_byte[2:0]};
    assign uni_acc = {r_val[27:0], hex_v};
    assign cnt_inc = r_cnt + 4'd1;

    always_comb begin
        res      = '0;
        n_mode   = r_mode;
        n_val    = r_val;
        n_cnt    = r_cnt;
        do_plain = 1'b0;

        unique case (r_mode)
            M_BSL: begin
                n_mode = M_PLAIN;
                n_val  = '0;
                n_cnt  = '0;
                if (is_oct) begin
                    n_mode = M_OCT;
                    n_val  = {29'd0, i_byte[2:0]};
                    n_cnt  = 4'd1;
                end else if (i_byte == ChNewline) begin
                    // A backslash-newline pair is a line continuation.
                end else if (i_byte == ChNul) begin
                    res = push(res, ChBackslash, 1'b0);
                    res = push(res, ChNul, 1'b0);
                end else if (i_byte == ChLowerX && !i_posix) begin
                    n_mode = M_XSTART;
                end else if (i_byte == ChLowerU && !i_posix) begin
                    n_mode = M_USTART;
                end else begin
                    res = push(res, simple_escape(i_byte), 1'b0);
                end
            end
            M_OCT: begin
                if (is_oct && cnt_inc < 4'(OctDigits)) begin
                    n_val = oct_acc;
                    n_cnt = cnt_inc;
                end else begin
                    res    = push(res, is_oct ? oct_acc[7:0] : r_val[7:0], 1'b0);
                    n_mode = M_PLAIN;
                    n_val  = '0;
                    n_cnt  = '0;
                    do_plain = !is_oct;
                end
            end
            M_XSTART, M_USTART: begin
                if (hex_ok) begin
                    n_mode = (r_mode == M_XSTART) ? M_XDIG : M_UDIG;
                    n_val  = {28'd0, hex_v};
                    n_cnt  = 4'd1;
                end else begin
                    res = push(res, (r_mode == M_XSTART) ? ChLowerX : ChLowerU, 1'b0);
                    n_mode   = M_PLAIN;
                    n_val    = '0;
                    n_cnt    = '0;
                    do_plain = 1'b1;
                end
            end
            M_XDIG: begin
                // Two hex digits fill a byte, so the second one ends the escape.
                res      = push(res, hex_ok ? {r_val[3:0], hex_v} : r_val[7:0], 1'b0);
                n_mode   = M_PLAIN;
                n_val    = '0;
                n_cnt    = '0;
                do_plain = !hex_ok;
            end
            M_UDIG: begin
                if (hex_ok && cnt_inc < 4'(UniDigits)) begin
                    n_val = uni_acc;
                    n_cnt = cnt_inc;
                end else begin
                    res      = push_utf8(res, hex_ok ? uni_acc : r_val);
                    n_mode   = M_PLAIN;
                    n_val    = '0;
                    n_cnt    = '0;
                    do_plain = !hex_ok;
                end
            end
            default: begin
                n_mode   = M_PLAIN;
                n_val    = '0;
                n_cnt    = '0;
                do_plain = 1'b1;
            end
        endcase

        // The byte that ended an escape is then taken as an ordinary byte.
        if (do_plain) begin
            if (i_byte == ChBackslash) begin
                n_mode = M_BSL;
                n_val  = '0;
                n_cnt  = '0;
            end else begin
                res = push(res, i_byte, 1'b0);
            end
        end

        if (i_eos) begin
            unique case (n_mode)
                M_BSL:          res = push(res, ChBackslash, 1'b0);
                M_OCT, M_XDIG:  res = push(res, n_val[7:0], 1'b0);
                M_XSTART:       res = push(res, ChLowerX, 1'b0);
                M_USTART:       res = push(res, ChLowerU, 1'b0);
                M_UDIG:         res = push_utf8(res, n_val);
                default:        ;
            endcase
            n_mode = M_PLAIN;
            n_val  = '0;
            n_cnt  = '0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_PLAIN;
            r_val  <= '0;
            r_cnt  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### design/esd_out_buf.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Escape decoder result buffer
// Holds the results of one byte and hands them out one per request.
// ------------------------------------------------------------------------
module esd_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  esd_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_free,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_err
);
    import esd_pkg::*;

    logic [MaxResults-1:0][7:0] r_data;
    logic [MaxResults-1:0]      r_err;
    logic [ResCntW-1:0]         r_rem;
    logic                       take;

    assign take    = o_valid && i_ready;
    assign o_valid = (r_rem != '0);
    assign o_last  = (r_rem == ResCntW'(1));
    assign o_byte  = r_data[0];
    assign o_err   = r_err[0];
    // The buffer can take a new list in the cycle its last entry leaves.
    assign o_free  = !o_valid || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_res.cnt;
        end else if (take) begin
            r_rem <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res.data;
            r_err  <= i_res.err;
        end else if (take) begin
            r_data <= {8'h00, r_data[MaxResults-1:1]};
            r_err  <= {1'b0, r_err[MaxResults-1:1]};
        end
    end

endmodule
